// ===== hw/rtl/fit_scale_pixel_address_mapper_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fit-scale pixel address mapper
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FIT_SCALE_PIXEL_ADDRESS_MAPPER_CORE_DEFINES_SVH
`define FIT_SCALE_PIXEL_ADDRESS_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge outside reset.
`define FSPAM_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("fspam assertion failed");
// Checked at every rising clock edge, during reset too.
`define FSPAM_ASSERT_ALWAYS(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("fspam assertion failed");
`else
`define FSPAM_ASSERT(name, clock, reset, prop)
`define FSPAM_ASSERT_ALWAYS(name, clock, prop)
`endif

`endif

// ===== hw/rtl/fspam_pkg.sv =====
// ----------------------------------------------------------------------------
// fspam_pkg
// Widths, register indexes and sequencer states of the pixel address mapper.
// ----------------------------------------------------------------------------
package fspam_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int FRAC_BITS = 16;

  localparam int DIM_W   = 11;                  // source sizes and image sizes
  localparam int COORD_W = 10;                  // screen and output coordinates
  localparam int IDX_W   = 20;                  // raster index
  localparam int SCALE_W = COORD_W + FRAC_BITS; // unsigned fixed-point scale
  localparam int NUM_W   = DIM_W + FRAC_BITS;   // dividend and quotient
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int PROD_W  = IDX_W + SCALE_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0]   DIV_STEPS = CNT_W'(NUM_W);
  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
  localparam logic [DIM_W-1:0]   MAX_SIZE  = DIM_W'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_RECT_LEFT   = 3'd2,
    REG_RECT_TOP    = 3'd3,
    REG_RECT_RIGHT  = 3'd4,
    REG_RECT_BOTTOM = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    FUNC_SETUP = 1'b0,
    FUNC_MAP   = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SA,
    ST_DIV_SB,
    ST_DIV_W,
    ST_DIV_H,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_IDX,
    ST_MAP_SUM,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/fspam_if.sv =====
// ----------------------------------------------------------------------------
// fspam_req_if / fspam_rsp_if
// Valid/ready channels carrying mapper requests and results.
// ----------------------------------------------------------------------------
interface fspam_req_if;
  import fspam_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;

  modport source (output valid, output func, output out_col, output out_row,
                  input ready);
  modport sink   (input valid, input func, input out_col, input out_row,
                  output ready);
endinterface

interface fspam_rsp_if;
  import fspam_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [COORD_W-1:0] win_x;
  logic [COORD_W-1:0] win_y;
  logic [DIM_W-1:0]   win_w;
  logic [DIM_W-1:0]   win_h;
  logic [IDX_W-1:0]   src_index;

  modport source (output valid, output ok, output win_x, output win_y,
                  output win_w, output win_h, output src_index, input ready);
  modport sink   (input valid, input ok, input win_x, input win_y,
                  input win_w, input win_h, input src_index, output ready);
endinterface

// ===== hw/rtl/fit_scale_pixel_address_mapper_core.sv =====
// ----------------------------------------------------------------------------
// fit_scale_pixel_address_mapper_core
// Nearest-neighbour fit scaling: frame setup and source pixel addressing.
//
//   channel  direction  handshake            payload
//   req      in         req.valid/req.ready  func, out_col, out_row
//   rsp      out        rsp.valid/rsp.ready  ok, win_x/y/w/h, src_index
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// A map transaction goes from acceptance to the result register through three
// passes of the shared multiplier, one add and the output load.
// A setup transaction runs four 27-step restoring divisions on one shared
// subtract unit; a rejected setup or map goes straight to the output load.
// One transaction is in flight at a time; req.ready is high only when idle.
// A result waiting on rsp does not block acceptance of the next request.
// Reset is synchronous and clears configuration and frame state to zero.
// ----------------------------------------------------------------------------
`include "fit_scale_pixel_address_mapper_core_defines.svh"

module fit_scale_pixel_address_mapper_core (
  input  logic                             clk,
  input  logic                             rst,
  fspam_req_if.sink                        req,
  fspam_rsp_if.source                      rsp,
  input  logic                             cfg_we,
  input  logic [fspam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fspam_pkg::DIM_W-1:0]      cfg_data
);
  import fspam_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]   src_width, src_height;
  logic [COORD_W-1:0] rect_left, rect_top, rect_right, rect_bottom;

  // Frame state
  logic [SCALE_W-1:0] scale_q;
  logic [DIM_W-1:0]   img_w, img_h;
  logic [COORD_W-1:0] org_x, org_y;
  logic               setup_valid;

  // Sequencer and working registers
  state_t             state, state_next;
  logic [DIM_W-1:0]   rw, rh;
  logic [COORD_W-1:0] col, row;
  logic [IDX_W-1:0]   sx;
  logic [PROD_W-1:0]  prod;
  logic               res_ok;
  logic [IDX_W-1:0]   res_idx;
  logic               out_valid;

  // Shared divider
  logic [NUM_W-1:0]   div_q;
  logic [SCALE_W-1:0] div_r;
  logic [SCALE_W-1:0] div_d;
  logic [CNT_W-1:0]   div_cnt;
  logic [SCALE_W:0]   div_trial;
  logic               div_ge;
  logic               div_done;

  // Combinational helpers
  logic               accept;
  logic               setup_err;
  logic [DIM_W-1:0]   rw_calc, rh_calc;
  logic               map_hit;
  logic [SCALE_W-1:0] q_sat;
  logic [SCALE_W-1:0] s_max;
  logic [DIM_W-1:0]   w_clamp, h_clamp;
  logic [IDX_W-1:0]   src_w_ext, src_h_ext;
  logic [IDX_W-1:0]   prod_int;
  logic [IDX_W-1:0]   sx_clamp, sy_clamp;
  logic [IDX_W-1:0]   mul_a;
  logic [SCALE_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_next;
  logic               out_load;
  logic               div_active;
  logic               frame_clear;

  assign accept   = req.valid && req.ready;
  assign out_load = (state == ST_OUT) && (!out_valid || rsp.ready);

  assign rw_calc = DIM_W'(rect_right - rect_left) + DIM_W'(1);
  assign rh_calc = DIM_W'(rect_bottom - rect_top) + DIM_W'(1);
  assign setup_err = (src_width == '0) || (src_height == '0) ||
                     (src_width > MAX_SIZE) || (src_height > MAX_SIZE) ||
                     (rect_right < rect_left) || (rect_bottom < rect_top);
  assign map_hit = setup_valid && ({1'b0, req.out_col} < img_w) &&
                   ({1'b0, req.out_row} < img_h);

  // One restoring division step per cycle.
  assign div_trial = {div_r, div_q[NUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_d};
  assign div_done  = (div_cnt == '0);

  // Quotient saturated to the scale width; the scale is never below one LSB.
  assign q_sat = div_q[NUM_W-1] ? SCALE_MAX : div_q[SCALE_W-1:0];
  always_comb begin
    s_max = (q_sat > scale_q) ? q_sat : scale_q;
    if (s_max == '0) begin
      s_max = SCALE_W'(1);
    end
  end
  assign w_clamp = (div_q > NUM_W'(rw)) ? rw : div_q[DIM_W-1:0];
  assign h_clamp = (div_q > NUM_W'(rh)) ? rh : div_q[DIM_W-1:0];

  // Source coordinates clamp to the last column or row, modulo the index width.
  assign src_w_ext = IDX_W'(src_width);
  assign src_h_ext = IDX_W'(src_height);
  assign prod_int  = prod[FRAC_BITS +: IDX_W];
  assign sx_clamp  = (prod_int >= src_w_ext) ? src_w_ext - IDX_W'(1) : prod_int;
  assign sy_clamp  = (prod_int >= src_h_ext) ? src_h_ext - IDX_W'(1) : prod_int;

  // Shared multiplier operands
  always_comb begin
    mul_a = IDX_W'(col);
    mul_b = scale_q;
    case (state)
      ST_MAP_Y:   mul_a = IDX_W'(row);
      ST_MAP_IDX: begin
        mul_a = sy_clamp;
        mul_b = SCALE_W'(src_width);
      end
      default:    ;
    endcase
  end
  assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_SETUP) begin
            state_next = setup_err ? ST_OUT : ST_DIV_SA;
          end else begin
            state_next = map_hit ? ST_MAP_X : ST_OUT;
          end
        end
      end
      ST_DIV_SA:  if (div_done) state_next = ST_DIV_SB;
      ST_DIV_SB:  if (div_done) state_next = ST_DIV_W;
      ST_DIV_W:   if (div_done) state_next = ST_DIV_H;
      ST_DIV_H:   if (div_done) state_next = ST_OUT;
      ST_MAP_X:   state_next = ST_MAP_Y;
      ST_MAP_Y:   state_next = ST_MAP_IDX;
      ST_MAP_IDX: state_next = ST_MAP_SUM;
      ST_MAP_SUM: state_next = ST_OUT;
      ST_OUT:     if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= '0;
      src_height  <= '0;
      rect_left   <= '0;
      rect_top    <= '0;
      rect_right  <= '0;
      rect_bottom <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:   src_width   <= cfg_data;
        REG_SRC_HEIGHT:  src_height  <= cfg_data;
        REG_RECT_LEFT:   rect_left   <= cfg_data[COORD_W-1:0];
        REG_RECT_TOP:    rect_top    <= cfg_data[COORD_W-1:0];
        REG_RECT_RIGHT:  rect_right  <= cfg_data[COORD_W-1:0];
        REG_RECT_BOTTOM: rect_bottom <= cfg_data[COORD_W-1:0];
        default:         ;
      endcase
    end
  end

  // Frame state and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q     <= '0;
      img_w       <= '0;
      img_h       <= '0;
      org_x       <= '0;
      org_y       <= '0;
      setup_valid <= 1'b0;
      div_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (div_cnt != '0) begin
        div_cnt <= div_cnt - CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (accept && (req.func == FUNC_SETUP)) begin
            setup_valid <= 1'b0;
            if (setup_err) begin
              scale_q <= '0;
              img_w   <= '0;
              img_h   <= '0;
              org_x   <= '0;
              org_y   <= '0;
            end else begin
              div_cnt <= DIV_STEPS;
            end
          end
        end
        ST_DIV_SA: begin
          if (div_done) begin
            scale_q <= q_sat;
            div_cnt <= DIV_STEPS;
          end
        end
        ST_DIV_SB: begin
          if (div_done) begin
            scale_q <= s_max;
            div_cnt <= DIV_STEPS;
          end
        end
        ST_DIV_W: begin
          if (div_done) begin
            img_w   <= w_clamp;
            div_cnt <= DIV_STEPS;
          end
        end
        ST_DIV_H: begin
          if (div_done) begin
            img_h       <= h_clamp;
            org_x       <= rect_left + COORD_W'((rw - img_w) >> 1);
            org_y       <= rect_top + COORD_W'((rh - h_clamp) >> 1);
            setup_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider and map datapath; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rw      <= rw_calc;
        rh      <= rh_calc;
        col     <= req.out_col;
        row     <= req.out_row;
        res_ok  <= 1'b0;
        res_idx <= '0;
        div_q   <= {src_width, FRAC_BITS'(0)};
        div_r   <= '0;
        div_d   <= SCALE_W'(rw_calc);
      end
      ST_DIV_SA, ST_DIV_SB, ST_DIV_W, ST_DIV_H: begin
        if (!div_done) begin
          div_q <= {div_q[NUM_W-2:0], div_ge};
          div_r <= div_ge ? SCALE_W'(div_trial - {1'b0, div_d}) :
                            div_trial[SCALE_W-1:0];
        end else begin
          // Load the next division of the chain.
          div_r <= '0;
          if (state == ST_DIV_SA) begin
            div_q <= {src_height, FRAC_BITS'(0)};
            div_d <= SCALE_W'(rh);
          end else if (state == ST_DIV_SB) begin
            div_q <= {src_width, FRAC_BITS'(0)};
            div_d <= s_max;
          end else begin
            div_q <= {src_height, FRAC_BITS'(0)};
            div_d <= scale_q;
          end
          if (state == ST_DIV_H) begin
            res_ok <= 1'b1;
          end
        end
      end
      ST_MAP_X:   prod <= prod_next;
      ST_MAP_Y: begin
        sx   <= sx_clamp;
        prod <= prod_next;
      end
      ST_MAP_IDX: prod <= prod_next;
      ST_MAP_SUM: begin
        res_idx <= prod[IDX_W-1:0] + sx;
        res_ok  <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.ok        <= res_ok;
      rsp.win_x     <= org_x;
      rsp.win_y     <= org_y;
      rsp.win_w     <= img_w;
      rsp.win_h     <= img_h;
      rsp.src_index <= res_idx;
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = (state == ST_IDLE);

  assign div_active  = (state == ST_DIV_SA) || (state == ST_DIV_SB) ||
                       (state == ST_DIV_W) || (state == ST_DIV_H);
  assign frame_clear = (scale_q == '0) && (img_w == '0) && (img_h == '0);

  // The divider only counts while a division state owns it.
  `FSPAM_ASSERT(a_div_owner, clk, rst, (div_cnt != '0) |-> div_active)
  // Every accepted request starts work.
  `FSPAM_ASSERT(a_accept_leaves_idle, clk, rst, accept |=> (state != ST_IDLE))
  // Idle without a valid frame, the scale and the image size are all zero.
  `FSPAM_ASSERT(a_idle_cleared, clk, rst, ((state == ST_IDLE) && !setup_valid) |-> frame_clear)
  // A valid frame never has a zero scale.
  `FSPAM_ASSERT_ALWAYS(a_scale_nonzero, clk, setup_valid |-> (scale_q != '0))

endmodule

// ===== tb/sv/fit_scale_pixel_address_mapper_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_scale_pixel_address_mapper_core_test
// Drives frame setup and pixel map transactions through the mapper and checks
// every result against an in-order prediction of ok flag, window and index.
// ----------------------------------------------------------------------------
module fit_scale_pixel_address_mapper_core_test;
  import fspam_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PERCENT = 30;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] win_x;
    logic [COORD_W-1:0] win_y;
    logic [DIM_W-1:0]   win_w;
    logic [DIM_W-1:0]   win_h;
    logic [IDX_W-1:0]   src_index;
  } mapping_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  fspam_req_if req_if ();
  fspam_rsp_if rsp_if ();

  fit_scale_pixel_address_mapper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted copy of the registers and of the frame state.
  logic [DIM_W-1:0]   src_w_reg, src_h_reg;
  logic [COORD_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
  logic [SCALE_W-1:0] frame_scale;
  logic [DIM_W-1:0]   frame_w, frame_h;
  logic [COORD_W-1:0] frame_x, frame_y;
  logic               frame_valid;

  mapping_t    pending_mappings[$];
  mapping_t    oldest_mapping;
  bit          idle_on = 1'b1;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_setup = 0, n_map = 0, n_hits = 0, n_frames = 0;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fit_scale_pixel_address_mapper_core_test failed");
      $finish;
    end
  end

  function automatic void clear_frame();
    frame_scale = '0;
    frame_w     = '0;
    frame_h     = '0;
    frame_x     = '0;
    frame_y     = '0;
    frame_valid = 1'b0;
  endfunction

  // Updates the frame state as the block does and returns the result it owes.
  function automatic mapping_t predict_mapping(func_e f, logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row);
    longint unsigned rw, rh, sa, sb, s, w, h, sx, sy;
    mapping_t res;
    res = '0;
    if (f == FUNC_SETUP) begin
      if (src_w_reg == 0 || src_h_reg == 0 || src_w_reg > MAX_DIM ||
          src_h_reg > MAX_DIM || right_reg < left_reg || bottom_reg < top_reg) begin
        clear_frame();
      end else begin
        rw = 64'(right_reg) - 64'(left_reg) + 1;
        rh = 64'(bottom_reg) - 64'(top_reg) + 1;
        sa = (64'(src_w_reg) << FRAC_BITS) / rw;
        sb = (64'(src_h_reg) << FRAC_BITS) / rh;
        s  = (sb > sa) ? sb : sa;
        if (s > 64'(SCALE_MAX)) s = 64'(SCALE_MAX);
        if (s == 0) s = 1;
        w = (64'(src_w_reg) << FRAC_BITS) / s;
        h = (64'(src_h_reg) << FRAC_BITS) / s;
        if (w > rw) w = rw;
        if (h > rh) h = rh;
        frame_scale = SCALE_W'(s);
        frame_w     = DIM_W'(w);
        frame_h     = DIM_W'(h);
        frame_x     = COORD_W'(64'(left_reg) + (rw - w) / 2);
        frame_y     = COORD_W'(64'(top_reg) + (rh - h) / 2);
        frame_valid = 1'b1;
      end
      res.ok = frame_valid;
    end else if (frame_valid && col < frame_w && row < frame_h) begin
      sx = (64'(col) * 64'(frame_scale)) >> FRAC_BITS;
      sy = (64'(row) * 64'(frame_scale)) >> FRAC_BITS;
      if (sx >= src_w_reg) sx = 64'(src_w_reg) - 1;
      if (sy >= src_h_reg) sy = 64'(src_h_reg) - 1;
      res.ok        = 1'b1;
      res.src_index = IDX_W'(sy * 64'(src_w_reg) + sx);
    end
    res.win_x = frame_x;
    res.win_y = frame_y;
    res.win_w = frame_w;
    res.win_h = frame_h;
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_mappings.size() == 0) begin
        $error("result transaction arrived with nothing outstanding");
        errors++;
      end else begin
        oldest_mapping = pending_mappings.pop_front();
        check_field("ok", oldest_mapping.ok, rsp_if.ok);
        check_field("win_x", oldest_mapping.win_x, rsp_if.win_x);
        check_field("win_y", oldest_mapping.win_y, rsp_if.win_y);
        check_field("win_w", oldest_mapping.win_w, rsp_if.win_w);
        check_field("win_h", oldest_mapping.win_h, rsp_if.win_h);
        check_field("src_index", oldest_mapping.src_index, rsp_if.src_index);
        if (rsp_if.ok) n_hits++;
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  task automatic send_item(func_e f, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= f;
    req_if.out_col <= col;
    req_if.out_row <= row;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_mappings.push_back(predict_mapping(f, col, row));
    if (f == FUNC_SETUP) n_setup++;
    else n_map++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_mappings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:   src_w_reg  = data;
      REG_SRC_HEIGHT:  src_h_reg  = data;
      REG_RECT_LEFT:   left_reg   = data[COORD_W-1:0];
      REG_RECT_TOP:    top_reg    = data[COORD_W-1:0];
      REG_RECT_RIGHT:  right_reg  = data[COORD_W-1:0];
      REG_RECT_BOTTOM: bottom_reg = data[COORD_W-1:0];
      default: ;
    endcase
  endtask

  // The top bit of a rectangle write is random: the register keeps ten bits.
  task automatic set_frame(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                           logic [COORD_W-1:0] l, logic [COORD_W-1:0] t,
                           logic [COORD_W-1:0] r, logic [COORD_W-1:0] b);
    wait_idle();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_RECT_LEFT, {1'($urandom_range(0, 1)), l});
    write_reg(REG_RECT_TOP, {1'($urandom_range(0, 1)), t});
    write_reg(REG_RECT_RIGHT, {1'($urandom_range(0, 1)), r});
    write_reg(REG_RECT_BOTTOM, {1'($urandom_range(0, 1)), b});
    n_frames++;
  endtask

  function automatic logic [DIM_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return DIM_W'(1);
      1:       return MAX_SIZE;
      default: return DIM_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  task automatic send_setup();
    send_item(FUNC_SETUP, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // Mostly pixels inside the current image, the rest anywhere on the grid.
  task automatic send_map();
    logic [COORD_W-1:0] col, row;
    if (frame_valid && frame_w != 0 && frame_h != 0 && $urandom_range(0, 99) < 85) begin
      col = COORD_W'($urandom_range(0, frame_w - 1));
      row = COORD_W'($urandom_range(0, frame_h - 1));
    end else begin
      col = COORD_W'($urandom);
      row = COORD_W'($urandom);
    end
    send_item(FUNC_MAP, col, row);
  endtask

  task automatic test_map_without_setup();
    send_item(FUNC_MAP, '0, '0);
    send_item(FUNC_MAP, '1, '1);
    // With the reset registers a setup fails on the zero source size.
    send_setup();
    send_item(FUNC_MAP, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic test_setup_errors();
    set_frame('0, 11'd100, 10'd0, 10'd0, 10'd99, 10'd99);
    send_setup();
    set_frame(11'd100, '0, 10'd0, 10'd0, 10'd99, 10'd99);
    send_setup();
    set_frame(DIM_W'(MAX_DIM + 1), 11'd100, 10'd0, 10'd0, 10'd99, 10'd99);
    send_setup();
    set_frame(11'd100, '1, 10'd0, 10'd0, 10'd99, 10'd99);
    send_setup();
    set_frame(11'd100, 11'd100, 10'd500, 10'd0, 10'd499, 10'd99);
    send_setup();
    send_item(FUNC_MAP, '0, '0);
    set_frame(11'd100, 11'd100, 10'd0, 10'd10, 10'd99, 10'd9);
    send_setup();
    send_item(FUNC_MAP, '0, '0);
  endtask

  task automatic test_setup_extremes();
    // Full-size source into a single pixel saturates the scale.
    set_frame(MAX_SIZE, MAX_SIZE, '0, '0, '0, '0);
    send_setup();
    send_item(FUNC_MAP, '0, '0);
    send_item(FUNC_MAP, 10'd1, '0);
    // A single pixel spread over the whole screen.
    set_frame(11'd1, 11'd1, '0, '0, '1, '1);
    send_setup();
    send_item(FUNC_MAP, '1, '1);
    send_item(FUNC_MAP, '0, '0);
    // Tall thin source into a wide flat rectangle leaves an empty image.
    set_frame(11'd1, MAX_SIZE, '0, 10'd1023, '1, 10'd1023);
    send_setup();
    send_item(FUNC_MAP, '0, '0);
    set_frame(11'd640, 11'd480, 10'd100, 10'd50, 10'd419, 10'd289);
    send_setup();
    send_item(FUNC_MAP, COORD_W'(frame_w - 1), COORD_W'(frame_h - 1));
    send_item(FUNC_MAP, COORD_W'(frame_w), '0);
    send_item(FUNC_MAP, '0, COORD_W'(frame_h));
  endtask

  task automatic run_frames(int unsigned target);
    int unsigned start, n_maps;
    logic [DIM_W-1:0] sw, sh;
    logic [COORD_W-1:0] l, t, r, b;
    start = n_setup + n_map;
    while (n_setup + n_map - start < target) begin
      if ($urandom_range(0, 99) < 10) begin
        sw = DIM_W'($urandom);
        sh = DIM_W'($urandom);
        l  = COORD_W'($urandom);
        t  = COORD_W'($urandom);
        r  = COORD_W'($urandom);
        b  = COORD_W'($urandom);
      end else begin
        sw = pick_size();
        sh = pick_size();
        if ($urandom_range(0, 4) == 0) begin
          l = '0;
          t = '0;
          r = '1;
          b = '1;
        end else begin
          l = COORD_W'($urandom);
          t = COORD_W'($urandom);
          r = COORD_W'($urandom_range(l, 1023));
          b = COORD_W'($urandom_range(t, 1023));
        end
      end
      set_frame(sw, sh, l, t, r, b);
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, DIM_W'($urandom));
      send_setup();
      n_maps = $urandom_range(4, 30);
      repeat (n_maps) begin
        if ($urandom_range(0, 99) < 3) send_setup();
        else send_map();
      end
    end
  endtask

  task automatic test_random_frames();
    run_frames(1000);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_frames(250);
    wait_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_SETUP;
    req_if.out_col = '0;
    req_if.out_row = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SRC_WIDTH;
    cfg_data       = '0;
    src_w_reg      = '0;
    src_h_reg      = '0;
    left_reg       = '0;
    top_reg        = '0;
    right_reg      = '0;
    bottom_reg     = '0;
    clear_frame();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_map_without_setup();
    test_setup_errors();
    test_setup_extremes();
    test_random_frames();
    test_back_to_back();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d frame settings with %0d setup and %0d map transactions,",
             n_frames, n_setup, n_map);
    $display("of which %0d came back with ok set, in %0d cycles.", n_hits, cycles);
    if (errors == 0) begin
      $display("fit_scale_pixel_address_mapper_core_test passed");
    end else begin
      $display("fit_scale_pixel_address_mapper_core_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fspam_pkg.sv
hw/rtl/fspam_if.sv
hw/rtl/fit_scale_pixel_address_mapper_core.sv
tb/sv/fit_scale_pixel_address_mapper_core_test.sv
